[src/nuf_pkg.sv]
// Shared widths, register indexes, FU header bits and controller/datapath structs.
package nuf_pkg;

  localparam int FILL_BITS     = 20;
  localparam int MAX_FRAGMENTS = 64;

  localparam int LEN_W     = 14;
  localparam int TYPE_W    = 6;
  localparam int OFFSET_W  = 20;
  localparam int FUH_W     = 8;
  localparam int MAXPL_W   = 11;
  localparam int PREFIX_W  = 2;
  localparam int HDR_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = MAXPL_W;

  // Running position holds the unsaturated fill: one bit above the fill.
  localparam int POS_W = FILL_BITS + 1;
  localparam int NUM_W = $clog2(MAX_FRAGMENTS + 1);

  // Shared divider: dividend covers rest + chunk - 1, divisor covers chunk.
  localparam int DIVIDEND_W = LEN_W + 1;
  localparam int DIVISOR_W  = MAXPL_W;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LEN  = 2'd2;

  localparam logic [MAXPL_W-1:0]  MAX_PAYLOAD_RST = 11'd1200;
  localparam logic [PREFIX_W-1:0] PREFIX_LEN_RST  = 2'd2;
  localparam logic [HDR_W-1:0]    HEADER_LEN_RST  = 2'd1;

  localparam logic [FUH_W-1:0] FU_TYPE_MASK = 8'b00_111111;
  localparam logic [FUH_W-1:0] FU_S_BIT     = 8'b10_000000;
  localparam logic [FUH_W-1:0] FU_E_BIT     = 8'b01_000000;

  localparam logic [POS_W-1:0] PREFIX_BYTES = POS_W'(4);

  typedef struct packed {
    logic load;         // take the input item, advance the frame fill
    logic start_num;    // start fragment count division
    logic take_num;     // capture the saturated fragment count
    logic start_split;  // start the even split division
    logic take_split;   // capture base size and remainder
    logic emit;         // load the output register with the next packet
  } ctrl_cmd_t;

  typedef struct packed {
    logic single;       // current NAL goes out as one single-NAL packet
    logic div_done;     // divider result is valid
    logic out_free;     // output register can take a packet this cycle
    logic last_item;    // packet about to be emitted is the final one
  } dp_status_t;

endpackage

[src/nal_unit_fragmenter.sv]
// Top level of the NAL unit fragmenter: sequencer plus sizing datapath.
//
//   channel  dir     handshake                 payload
//   in       sink    in_valid_i/in_stall_o     nal_length, fu_type, frame_start
//   out      source  out_valid_o/out_stall_i   offset, length, fragment, fu_header, last, ovf
//   cfg      sink    cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One NAL at a time. A single NAL goes from PREP straight to EMIT, skipping the divider.
// A fragmented NAL first runs the shared one-bit-per-cycle divider twice (fragment
// count, then the even split), then emits one packet per cycle while not stalled.
// Reset clears the frame fill and loads the register defaults. A stalled output holds
// its packet; the next item is taken once the NAL's last packet sits in the output register.
module nal_unit_fragmenter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [nuf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nuf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [nuf_pkg::LEN_W-1:0]       nal_length_i,
  input  logic [nuf_pkg::TYPE_W-1:0]      fu_type_i,
  input  logic                            frame_start_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [nuf_pkg::OFFSET_W-1:0]    payload_offset_o,
  output logic [nuf_pkg::LEN_W-1:0]       payload_length_o,
  output logic                            is_fragment_o,
  output logic [nuf_pkg::FUH_W-1:0]       fu_header_o,
  output logic                            last_o,
  output logic                            fill_overflow_o
);

  nuf_pkg::ctrl_cmd_t  cmd;
  nuf_pkg::dp_status_t status;

  // Sequencer: steps each NAL through sizing and emission.
  nuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: frame fill, divider, fragment sizes and the output register.
  nuf_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .nal_length_i     (nal_length_i),
    .fu_type_i        (fu_type_i),
    .frame_start_i    (frame_start_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_offset_o (payload_offset_o),
    .payload_length_o (payload_length_o),
    .is_fragment_o    (is_fragment_o),
    .fu_header_o      (fu_header_o),
    .last_o           (last_o),
    .fill_overflow_o  (fill_overflow_o)
  );

endmodule

[src/nuf_div.sv]
// Restoring divider, one quotient bit per cycle.
module nuf_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [nuf_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [nuf_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                           done_o,
  output logic [nuf_pkg::DIVIDEND_W-1:0] quotient_o,
  output logic [nuf_pkg::DIVISOR_W-1:0]  remainder_o
);

  localparam int CNT_W = $clog2(nuf_pkg::DIVIDEND_W + 1);

  logic [nuf_pkg::DIVIDEND_W-1:0] quo_q, quo_d;
  logic [nuf_pkg::DIVISOR_W-1:0]  rem_q, rem_d;
  logic [nuf_pkg::DIVISOR_W-1:0]  dvs_q;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [nuf_pkg::DIVISOR_W:0]    trial;
  logic [nuf_pkg::DIVISOR_W:0]    diff;
  logic                           fits;

  always_comb begin
    trial  = {rem_q, quo_q[nuf_pkg::DIVIDEND_W-1]};
    diff   = trial - {1'b0, dvs_q};
    fits   = (trial >= {1'b0, dvs_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(nuf_pkg::DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[nuf_pkg::DIVIDEND_W-2:0], fits};
      rem_d = fits ? diff[nuf_pkg::DIVISOR_W-1:0] : trial[nuf_pkg::DIVISOR_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[src/nuf_ctrl.sv]
// Sequencer: accept, count division, split division, packet emission.
module nuf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nuf_pkg::dp_status_t status_i,
  output nuf_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_NUM,
    ST_SPLIT_START,
    ST_DIV_SPLIT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status_i.single) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.start_num = 1'b1;
          state_d         = ST_DIV_NUM;
        end
      end
      ST_DIV_NUM: begin
        if (status_i.div_done) begin
          cmd_o.take_num = 1'b1;
          state_d        = ST_SPLIT_START;
        end
      end
      ST_SPLIT_START: begin
        cmd_o.start_split = 1'b1;
        state_d           = ST_DIV_SPLIT;
      end
      ST_DIV_SPLIT: begin
        if (status_i.div_done) begin
          cmd_o.take_split = 1'b1;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_item) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

[src/nuf_datapath.sv]
// Config registers, frame fill, fragment sizing and the output register.
module nuf_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nuf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nuf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [nuf_pkg::LEN_W-1:0]       nal_length_i,
  input  logic [nuf_pkg::TYPE_W-1:0]      fu_type_i,
  input  logic                            frame_start_i,
  input  nuf_pkg::ctrl_cmd_t              cmd_i,
  output nuf_pkg::dp_status_t             status_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [nuf_pkg::OFFSET_W-1:0]    payload_offset_o,
  output logic [nuf_pkg::LEN_W-1:0]       payload_length_o,
  output logic                            is_fragment_o,
  output logic [nuf_pkg::FUH_W-1:0]       fu_header_o,
  output logic                            last_o,
  output logic                            fill_overflow_o
);

  localparam int FB = nuf_pkg::FILL_BITS;
  localparam int PW = nuf_pkg::POS_W;
  localparam int NW = nuf_pkg::NUM_W;

  // configuration
  logic [nuf_pkg::MAXPL_W-1:0]  max_payload_q;
  logic [nuf_pkg::PREFIX_W-1:0] prefix_len_q;
  logic [nuf_pkg::HDR_W-1:0]    header_len_q;

  // per-NAL state
  logic [FB-1:0]                fill_q;
  logic [PW-1:0]                pos_q;
  logic [nuf_pkg::LEN_W-1:0]    len_q;
  logic [nuf_pkg::LEN_W-1:0]    rest_q;
  logic [nuf_pkg::MAXPL_W-1:0]  chunk_q;
  logic [nuf_pkg::TYPE_W-1:0]   type_q;
  logic                         ovf_q;
  logic                         single_q;
  logic [NW-1:0]                num_q;
  logic [NW-1:0]                idx_q;
  logic [nuf_pkg::LEN_W-1:0]    base_q;
  logic [NW-1:0]                mod_q;

  // output register
  logic                         out_valid_q;
  logic [nuf_pkg::OFFSET_W-1:0] off_q;
  logic [nuf_pkg::LEN_W-1:0]    plen_q;
  logic                         frag_q;
  logic [nuf_pkg::FUH_W-1:0]    fuh_q;
  logic                         last_q;
  logic                         ovfo_q;

  logic [FB-1:0]                fill_eff;
  logic [PW-1:0]                pos_start;
  logic [PW-1:0]                total;
  logic [nuf_pkg::LEN_W-1:0]    max_pl_ext;
  logic [nuf_pkg::LEN_W-1:0]    hdr_ext;
  logic [nuf_pkg::MAXPL_W-1:0]  chunk_calc;
  logic [FB-1:0]                pos_clamped;
  logic [nuf_pkg::LEN_W-1:0]    frag_len;
  logic                         frag_fin;
  logic [nuf_pkg::FUH_W-1:0]    frag_fuh;
  logic                         out_free;

  logic                              div_start;
  logic [nuf_pkg::DIVIDEND_W-1:0]    div_dividend;
  logic [nuf_pkg::DIVISOR_W-1:0]     div_divisor;
  logic                              div_done;
  logic [nuf_pkg::DIVIDEND_W-1:0]    div_quo;
  logic [nuf_pkg::DIVISOR_W-1:0]     div_rem;
  logic [NW-1:0]                     num_sat;

  always_comb begin
    fill_eff   = frame_start_i ? '0 : fill_q;
    pos_start  = PW'(fill_eff) + nuf_pkg::PREFIX_BYTES;
    total      = pos_start + PW'(nal_length_i);
    max_pl_ext = nuf_pkg::LEN_W'(max_payload_q);
    hdr_ext    = nuf_pkg::LEN_W'(header_len_q);
    chunk_calc = (max_payload_q > nuf_pkg::MAXPL_W'(prefix_len_q))
               ? max_payload_q - nuf_pkg::MAXPL_W'(prefix_len_q)
               : nuf_pkg::MAXPL_W'(1);
  end

  // saturate the count at the fragment limit, never below one
  always_comb begin
    if (div_quo > nuf_pkg::DIVIDEND_W'(nuf_pkg::MAX_FRAGMENTS)) begin
      num_sat = NW'(nuf_pkg::MAX_FRAGMENTS);
    end else if (div_quo == '0) begin
      num_sat = NW'(1);
    end else begin
      num_sat = div_quo[NW-1:0];
    end
  end

  always_comb begin
    div_start    = cmd_i.start_num | cmd_i.start_split;
    div_dividend = cmd_i.start_num
                 ? nuf_pkg::DIVIDEND_W'(rest_q) + nuf_pkg::DIVIDEND_W'(chunk_q)
                   - nuf_pkg::DIVIDEND_W'(1)
                 : nuf_pkg::DIVIDEND_W'(rest_q);
    div_divisor  = cmd_i.start_num ? chunk_q : nuf_pkg::DIVISOR_W'(num_q);
  end

  nuf_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    pos_clamped = pos_q[FB] ? '1 : pos_q[FB-1:0];
    frag_len    = base_q + nuf_pkg::LEN_W'(idx_q < mod_q);
    frag_fin    = ((idx_q + NW'(1)) == num_q);
    frag_fuh    = nuf_pkg::FUH_W'(type_q) & nuf_pkg::FU_TYPE_MASK;
    if (idx_q == '0) begin
      frag_fuh = frag_fuh | nuf_pkg::FU_S_BIT;
    end
    if (frag_fin) begin
      frag_fuh = frag_fuh | nuf_pkg::FU_E_BIT;
    end
    out_free = !out_valid_q || !out_stall_i;
  end

  assign status_o.single    = single_q;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = out_free;
  assign status_o.last_item = single_q || frag_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= nuf_pkg::MAX_PAYLOAD_RST;
      prefix_len_q  <= nuf_pkg::PREFIX_LEN_RST;
      header_len_q  <= nuf_pkg::HEADER_LEN_RST;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          nuf_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_wdata_i;
          nuf_pkg::REG_PREFIX_LEN:  prefix_len_q  <= cfg_wdata_i[nuf_pkg::PREFIX_W-1:0];
          nuf_pkg::REG_HEADER_LEN:  header_len_q  <= cfg_wdata_i[nuf_pkg::HDR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        fill_q <= total[FB] ? '1 : total[FB-1:0];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q    <= pos_start;
      len_q    <= nal_length_i;
      type_q   <= fu_type_i;
      ovf_q    <= total[FB];
      single_q <= (nal_length_i < max_pl_ext) || (nal_length_i <= hdr_ext);
      rest_q   <= nal_length_i - hdr_ext;
      chunk_q  <= chunk_calc;
    end
    if (cmd_i.start_num) begin
      pos_q <= pos_q + PW'(header_len_q);
    end
    if (cmd_i.take_num) begin
      num_q <= num_sat;
    end
    if (cmd_i.take_split) begin
      base_q <= div_quo[nuf_pkg::LEN_W-1:0];
      mod_q  <= div_rem[NW-1:0];
      idx_q  <= '0;
    end
    if (cmd_i.emit) begin
      off_q  <= nuf_pkg::OFFSET_W'(pos_clamped);
      ovfo_q <= ovf_q;
      if (single_q) begin
        plen_q <= len_q;
        frag_q <= 1'b0;
        fuh_q  <= '0;
        last_q <= 1'b1;
      end else begin
        plen_q <= frag_len;
        frag_q <= 1'b1;
        fuh_q  <= frag_fuh;
        last_q <= frag_fin;
        pos_q  <= pos_q + PW'(frag_len);
        idx_q  <= idx_q + NW'(1);
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_offset_o = off_q;
  assign payload_length_o = plen_q;
  assign is_fragment_o    = frag_q;
  assign fu_header_o      = fuh_q;
  assign last_o           = last_q;
  assign fill_overflow_o  = ovfo_q;

endmodule
